FILE: src/cfd_pkg.sv
package cfd_pkg;

    localparam int VAL_W       = 10;
    localparam int OCC_W       = 7;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int MAX_SEEN    = 1024;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_DEDUP = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEQ,
        S_DD_RD,
        S_DD_SEEN,
        S_DD_CHK,
        S_DC_RD,
        S_DC_WR,
        S_DD_DONE,
        S_RO_RD,
        S_RO_OUT
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] data;
        status_t          status;
        logic [OCC_W-1:0] occupancy;
        logic             last;
    } res_t;

endpackage

FILE: src/cfd_ram.sv
module cfd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/cfd_modadd.sv
module cfd_modadd #(
    parameter int DEPTH = 8
) (
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] a,
    input  logic [$clog2(DEPTH + 1)-1:0]                 b,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] sum
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(DEPTH);

    logic [CNT_W:0] raw;
    logic [CNT_W:0] wrapped;

    // both operands stay below twice the depth, so one subtract wraps it
    always_comb
    begin
        raw     = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        wrapped = (raw >= LIMIT) ? (raw - LIMIT) : raw;
        sum     = wrapped[PTR_W-1:0];
    end

endmodule

FILE: src/cfd_ctrl.sv
module cfd_ctrl #(
    parameter int DEPTH       = 8,
    parameter int VALUE_RANGE = 1024
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  cfd_pkg::cmd_t                             in_cmd,
    input  logic [cfd_pkg::VAL_W-1:0]                 in_value,
    input  logic                                      out_free,
    output logic                                      res_valid,
    output cfd_pkg::res_t                             res,
    output logic                                      slot_wr_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] slot_wr_addr,
    output logic [cfd_pkg::VAL_W-1:0]                 slot_wr_data,
    output logic                                      slot_rd_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] slot_rd_addr,
    input  logic [cfd_pkg::VAL_W-1:0]                 slot_rd_data,
    output logic                                      seen_wr_en,
    output logic [$clog2((VALUE_RANGE < cfd_pkg::MAX_SEEN) ? VALUE_RANGE
                         : cfd_pkg::MAX_SEEN)-1:0]    seen_wr_addr,
    output logic [0:0]                                seen_wr_data,
    output logic                                      seen_rd_en,
    output logic [$clog2((VALUE_RANGE < cfd_pkg::MAX_SEEN) ? VALUE_RANGE
                         : cfd_pkg::MAX_SEEN)-1:0]    seen_rd_addr,
    input  logic [0:0]                                seen_rd_data
);

    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SEEN_DEPTH = (VALUE_RANGE < cfd_pkg::MAX_SEEN) ? VALUE_RANGE
                                : cfd_pkg::MAX_SEEN;
    localparam int SEEN_AW    = $clog2(SEEN_DEPTH);
    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [SEEN_AW-1:0] SEEN_LAST = SEEN_AW'(SEEN_DEPTH - 1);
    localparam logic [16:0]        RANGE_LIM = 17'(VALUE_RANGE);

    cfd_pkg::state_t              state_reg, state_next;
    logic [PTR_W-1:0]             head_reg, head_next;
    logic [PTR_W-1:0]             tail_reg, tail_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [PTR_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             kept_reg, kept_next;
    logic [SEEN_AW-1:0]           clr_reg, clr_next;
    logic [cfd_pkg::VAL_W-1:0]    val_reg, val_next;

    logic [PTR_W-1:0]             add_a;
    logic [CNT_W-1:0]             add_b;
    logic [PTR_W-1:0]             add_sum;
    logic                         accept;
    logic                         idx_last;
    logic                         keep;

    function automatic logic in_range(input logic [cfd_pkg::VAL_W-1:0] v);
        return {7'd0, v} < RANGE_LIM;
    endfunction

    // shared ring-index adder
    cfd_modadd #(
        .DEPTH (DEPTH)
    ) u_add (
        .a   (add_a),
        .b   (add_b),
        .sum (add_sum)
    );

    assign in_ready = (state_reg == cfd_pkg::S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign keep     = !(in_range(val_reg) && seen_rd_data[0]);

    // outputs and datapath controls
    always_comb
    begin
        add_a        = head_reg;
        add_b        = '0;
        res_valid    = 1'b0;
        res          = '0;
        slot_wr_en   = 1'b0;
        slot_wr_addr = tail_reg;
        slot_wr_data = in_value;
        slot_rd_en   = 1'b0;
        slot_rd_addr = head_reg;
        seen_wr_en   = 1'b0;
        seen_wr_addr = clr_reg;
        seen_wr_data = 1'b0;
        seen_rd_en   = 1'b0;
        seen_rd_addr = slot_rd_data[SEEN_AW-1:0];
        case (state_reg)
            cfd_pkg::S_CLEAR:
            begin
                seen_wr_en = 1'b1;
            end
            cfd_pkg::S_IDLE:
            begin
                add_a = tail_reg;
                add_b = CNT_W'(1);
                if (accept)
                begin
                    res.last      = 1'b1;
                    res.occupancy = cfd_pkg::OCC_W'(count_reg);
                    case (in_cmd)
                        cfd_pkg::CMD_ENQ:
                        begin
                            res_valid = 1'b1;
                            if (count_reg == CNT_FULL)
                            begin
                                res.status = cfd_pkg::ST_FULL;
                            end
                            else
                            begin
                                slot_wr_en    = 1'b1;
                                res.status    = cfd_pkg::ST_OK;
                                res.occupancy = cfd_pkg::OCC_W'(count_reg + CNT_W'(1));
                            end
                        end
                        cfd_pkg::CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = cfd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                slot_rd_en = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = cfd_pkg::ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            cfd_pkg::S_DEQ:
            begin
                add_b = CNT_W'(1);
                if (out_free)
                begin
                    res_valid     = 1'b1;
                    res.data      = slot_rd_data;
                    res.status    = cfd_pkg::ST_OK;
                    res.occupancy = cfd_pkg::OCC_W'(count_reg - CNT_W'(1));
                    res.last      = 1'b1;
                end
            end
            cfd_pkg::S_DD_RD, cfd_pkg::S_DC_RD, cfd_pkg::S_RO_RD:
            begin
                add_b        = CNT_W'(idx_reg);
                slot_rd_en   = 1'b1;
                slot_rd_addr = add_sum;
            end
            cfd_pkg::S_DD_SEEN:
            begin
                seen_rd_en = in_range(slot_rd_data);
            end
            cfd_pkg::S_DD_CHK:
            begin
                // survivors are packed behind the head, never ahead of the read index
                add_b = kept_reg;
                if (keep)
                begin
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = add_sum;
                    slot_wr_data = val_reg;
                    seen_wr_en   = in_range(val_reg);
                    seen_wr_addr = val_reg[SEEN_AW-1:0];
                    seen_wr_data = 1'b1;
                end
            end
            cfd_pkg::S_DC_WR:
            begin
                // the marked values are exactly the survivors, so clear them again
                seen_wr_en   = in_range(slot_rd_data);
                seen_wr_addr = slot_rd_data[SEEN_AW-1:0];
            end
            cfd_pkg::S_DD_DONE:
            begin
                add_b = kept_reg;
                if (out_free)
                begin
                    res_valid     = 1'b1;
                    res.status    = cfd_pkg::ST_OK;
                    res.occupancy = cfd_pkg::OCC_W'(kept_reg);
                    res.last      = 1'b1;
                end
            end
            cfd_pkg::S_RO_OUT:
            begin
                if (out_free)
                begin
                    res_valid     = 1'b1;
                    res.data      = slot_rd_data;
                    res.status    = cfd_pkg::ST_OK;
                    res.occupancy = cfd_pkg::OCC_W'(count_reg);
                    res.last      = idx_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    // next state and register updates
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        kept_next  = kept_reg;
        clr_next   = clr_reg;
        val_next   = val_reg;
        case (state_reg)
            cfd_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + SEEN_AW'(1);
                if (clr_reg == SEEN_LAST)
                begin
                    state_next = cfd_pkg::S_IDLE;
                end
            end
            cfd_pkg::S_IDLE:
            begin
                if (accept && (count_reg != '0 || in_cmd == cfd_pkg::CMD_ENQ))
                begin
                    idx_next  = '0;
                    kept_next = '0;
                    case (in_cmd)
                        cfd_pkg::CMD_ENQ:
                        begin
                            if (count_reg != CNT_FULL)
                            begin
                                tail_next  = add_sum;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        cfd_pkg::CMD_DEQ:
                        begin
                            state_next = cfd_pkg::S_DEQ;
                        end
                        cfd_pkg::CMD_DEDUP:
                        begin
                            state_next = cfd_pkg::S_DD_RD;
                        end
                        cfd_pkg::CMD_READ:
                        begin
                            state_next = cfd_pkg::S_RO_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cfd_pkg::S_DEQ:
            begin
                if (out_free)
                begin
                    head_next  = add_sum;
                    count_next = count_reg - CNT_W'(1);
                    state_next = cfd_pkg::S_IDLE;
                end
            end
            cfd_pkg::S_DD_RD:
            begin
                state_next = cfd_pkg::S_DD_SEEN;
            end
            cfd_pkg::S_DD_SEEN:
            begin
                val_next   = slot_rd_data;
                state_next = cfd_pkg::S_DD_CHK;
            end
            cfd_pkg::S_DD_CHK:
            begin
                if (keep)
                begin
                    kept_next = kept_reg + CNT_W'(1);
                end
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = cfd_pkg::S_DC_RD;
                end
                else
                begin
                    idx_next   = idx_reg + PTR_W'(1);
                    state_next = cfd_pkg::S_DD_RD;
                end
            end
            cfd_pkg::S_DC_RD:
            begin
                state_next = cfd_pkg::S_DC_WR;
            end
            cfd_pkg::S_DC_WR:
            begin
                if ((CNT_W'(idx_reg) + CNT_W'(1)) == kept_reg)
                begin
                    state_next = cfd_pkg::S_DD_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + PTR_W'(1);
                    state_next = cfd_pkg::S_DC_RD;
                end
            end
            cfd_pkg::S_DD_DONE:
            begin
                if (out_free)
                begin
                    tail_next  = add_sum;
                    count_next = kept_reg;
                    state_next = cfd_pkg::S_IDLE;
                end
            end
            cfd_pkg::S_RO_RD:
            begin
                state_next = cfd_pkg::S_RO_OUT;
            end
            cfd_pkg::S_RO_OUT:
            begin
                if (out_free)
                begin
                    if (idx_last)
                    begin
                        state_next = cfd_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + PTR_W'(1);
                        state_next = cfd_pkg::S_RO_RD;
                    end
                end
            end
            default:
            begin
                state_next = cfd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfd_pkg::S_CLEAR;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            kept_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            kept_reg  <= kept_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

FILE: src/circular_fifo_with_dedupe_top.sv
// enqueue, and any other command that finds the queue empty: result in the following cycle,
// one item per cycle while out_free holds; dequeue: through the registered slot read port
// read-out: slot read, then output, per entry; dedupe: read, seen lookup, check per entry,
// then read, clear per kept one, all sharing one ring-index adder and one slot read port
// reset: pointers and count clear at once, then the min(VALUE_RANGE, 1024) entries of the
// seen bitmap are swept clear with s_tready low
module circular_fifo_with_dedupe_top #(
    parameter int DEPTH       = 8,
    parameter int VALUE_RANGE = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfd_pkg::S_TDATA_W-1:0]     s_tdata,  // cmd[1:0], value[11:2]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfd_pkg::M_TDATA_W-1:0]     m_tdata,  // data[9:0], status[11:10],
                                                        // occupancy[18:12]
    output logic                              m_tlast
);

    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEEN_DEPTH = (VALUE_RANGE < cfd_pkg::MAX_SEEN) ? VALUE_RANGE
                                : cfd_pkg::MAX_SEEN;
    localparam int SEEN_AW    = $clog2(SEEN_DEPTH);

    logic                         m_tvalid_reg;
    cfd_pkg::res_t                res_reg;
    logic                         out_free;
    logic                         res_valid;
    cfd_pkg::res_t                res;

    logic                         slot_wr_en;
    logic [PTR_W-1:0]             slot_wr_addr;
    logic [cfd_pkg::VAL_W-1:0]    slot_wr_data;
    logic                         slot_rd_en;
    logic [PTR_W-1:0]             slot_rd_addr;
    logic [cfd_pkg::VAL_W-1:0]    slot_rd_data;
    logic                         seen_wr_en;
    logic [SEEN_AW-1:0]           seen_wr_addr;
    logic [0:0]                   seen_wr_data;
    logic                         seen_rd_en;
    logic [SEEN_AW-1:0]           seen_rd_addr;
    logic [0:0]                   seen_rd_data;

    assign out_free = !m_tvalid_reg || m_tready;

    cfd_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_RANGE (VALUE_RANGE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (cfd_pkg::cmd_t'(s_tdata[1:0])),
        .in_value     (s_tdata[11:2]),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res),
        .slot_wr_en   (slot_wr_en),
        .slot_wr_addr (slot_wr_addr),
        .slot_wr_data (slot_wr_data),
        .slot_rd_en   (slot_rd_en),
        .slot_rd_addr (slot_rd_addr),
        .slot_rd_data (slot_rd_data),
        .seen_wr_en   (seen_wr_en),
        .seen_wr_addr (seen_wr_addr),
        .seen_wr_data (seen_wr_data),
        .seen_rd_en   (seen_rd_en),
        .seen_rd_addr (seen_rd_addr),
        .seen_rd_data (seen_rd_data)
    );

    cfd_ram #(
        .WIDTH (cfd_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    cfd_ram #(
        .WIDTH (1),
        .DEPTH (SEEN_DEPTH)
    ) u_seen (
        .clk     (clk),
        .wr_en   (seen_wr_en),
        .wr_addr (seen_wr_addr),
        .wr_data (seen_wr_data),
        .rd_en   (seen_rd_en),
        .rd_addr (seen_rd_addr),
        .rd_data (seen_rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, res_reg.occupancy, res_reg.status, res_reg.data};
    assign m_tlast  = res_reg.last;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!m_tvalid_reg || m_tready))
        else $error("result produced while the output register is still held");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_reg.occupancy <= cfd_pkg::OCC_W'(DEPTH)))
        else $error("occupancy above depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.status == cfd_pkg::ST_FULL)
            |-> (res_reg.occupancy == cfd_pkg::OCC_W'(DEPTH) && m_tlast))
        else $error("full status with queue not full");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.status != cfd_pkg::ST_OK) |-> m_tlast)
        else $error("error status on a non-final item");

endmodule
